// ===== rtl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Shared widths, device type codes and the control bundle that the peer
// address table broadcasts to its row of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

  localparam int ADDR_W = 48;
  localparam int TYPE_W = 2;
  localparam int SLOT_W = 5;

  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_SENSOR  = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_HEATER  = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_FLOW    = 2'd3;

  localparam logic KIND_LOOKUP   = 1'b0;
  localparam logic KIND_REGISTER = 1'b1;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic              cmp_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
  } pat_ctrl_t;

endpackage : pat_pkg

`default_nettype wire

// ===== rtl/pat_cell.sv =====
// ----------------------------------------------------------------------------
// pat_cell
// One entry of the peer address table: a valid bit, the stored address and
// a registered compare against the broadcast address. The valid bit is handed
// to the next cell so that the first empty cell takes an append.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_cell
  import pat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pat_ctrl_t ctrl,
  input  wire logic      prev_valid,
  output logic           valid,
  output logic           match
);

  logic              valid_r;
  logic              valid_nxt;
  logic              match_r;
  logic              match_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic              take;

  // This cell is the head of the free region when its left neighbor is in use.
  assign take = ctrl.wr_en && prev_valid && !valid_r;

  always_comb begin
    valid_nxt = valid_r | take;
    match_nxt = match_r;
    if (ctrl.cmp_en) begin
      match_nxt = valid_r && (addr_r == ctrl.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r <= ctrl.addr;
    end
  end

  assign valid = valid_r;
  assign match = match_r;

endmodule : pat_cell

`default_nettype wire

// ===== rtl/pat_hit_or.sv =====
// ----------------------------------------------------------------------------
// pat_hit_or
// Folds the per-cell match flags into a hit flag and the matching index.
// Stored addresses are unique, so at most one flag is set and an OR tree of
// the gated indices gives that entry's index.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_hit_or
  import pat_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic [DEPTH-1:0] match,
  output logic                  hit,
  output logic [IDX_W-1:0]      hit_idx
);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | ({IDX_W{match[i]}} & IDX_W'(i));
    end
    hit = |match;
  end

endmodule : pat_hit_or

`default_nettype wire

// ===== rtl/peer_address_table.sv =====
// ----------------------------------------------------------------------------
// peer_address_table
// Table of up to DEPTH unique 48-bit peer addresses, filled in arrival order,
// with lookup, register-if-absent and tracking of the newest heater and flow
// driver slots.
// ----------------------------------------------------------------------------
// Each item is handled in order: at the transfer edge each cell of the
// row compares its stored address against the incoming one and registers the
// outcome, and in the following cycle the match flags are folded into an
// index, an append is written into the first empty cell, and the result is
// loaded into the output register. A new item is taken only when idle and that
// register is empty or being emptied, so none is taken while the last resolves.
// The table needs no clearing pass: reset clears the per-cell valid bits, and
// the stored addresses are only ever compared in valid cells.
`default_nettype none

module peer_address_table
  import pat_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_kind,
  input  wire logic [ADDR_W-1:0] in_mac_address,
  input  wire logic [TYPE_W-1:0] in_device_type,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_found,
  output logic [SLOT_W-1:0]      out_entry_index,
  output logic                   out_added,
  output logic                   out_table_full,
  output logic [SLOT_W-1:0]      out_heater_slot,
  output logic                   out_heater_known,
  output logic [SLOT_W-1:0]      out_flow_slot,
  output logic                   out_flow_known
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Two-state sequencer: waiting for an item, then resolving it.
  localparam logic S_IDLE    = 1'b0;
  localparam logic S_RESOLVE = 1'b1;

  logic              state_r;
  logic              state_nxt;

  // The item held while it is resolved.
  logic              kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TYPE_W-1:0] dtype_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [IDX_W-1:0]  heater_r;
  logic [IDX_W-1:0]  heater_nxt;
  logic              heater_ok_r;
  logic              heater_ok_nxt;
  logic [IDX_W-1:0]  flow_r;
  logic [IDX_W-1:0]  flow_nxt;
  logic              flow_ok_r;
  logic              flow_ok_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              found_r;
  logic [IDX_W-1:0]  index_r;
  logic              added_r;
  logic              full_r;

  logic              in_xfer;
  logic              resolving;
  logic              table_is_full;
  logic              do_append;
  logic              do_refuse;
  logic [IDX_W-1:0]  append_idx;
  logic [IDX_W-1:0]  result_idx;

  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_match;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  pat_ctrl_t         ctrl;

  // --------------------------------------------------------------------------
  // Handshake. The output register is empty by the time the resolve cycle
  // loads it, because an item is only taken when it is empty or draining.
  // --------------------------------------------------------------------------
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign resolving = (state_r == S_RESOLVE);

  // --------------------------------------------------------------------------
  // Resolve: a hit wins; otherwise a register item appends or is refused.
  // --------------------------------------------------------------------------
  assign table_is_full = (count_r == CNT_FULL);
  assign append_idx    = count_r[IDX_W-1:0];
  assign do_append     = resolving && !hit && (kind_r == KIND_REGISTER) && !table_is_full;
  assign do_refuse     = !hit && (kind_r == KIND_REGISTER) && table_is_full;

  always_comb begin
    result_idx = '0;
    if (hit) begin
      result_idx = hit_idx;
    end else if (do_append) begin
      result_idx = append_idx;
    end
  end

  // During a transfer the cells see the incoming address for the compare;
  // during resolve they see the held address for a possible append.
  always_comb begin
    ctrl.cmp_en = in_xfer;
    ctrl.wr_en  = do_append;
    ctrl.addr   = resolving ? addr_r : in_mac_address;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    heater_nxt    = heater_r;
    heater_ok_nxt = heater_ok_r;
    flow_nxt      = flow_r;
    flow_ok_nxt   = flow_ok_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (do_append) begin
          count_nxt = count_r + CNT_W'(1);
          if (dtype_r == TYPE_HEATER) begin
            heater_nxt    = append_idx;
            heater_ok_nxt = 1'b1;
          end else if (dtype_r == TYPE_FLOW) begin
            flow_nxt    = append_idx;
            flow_ok_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      heater_r    <= '0;
      heater_ok_r <= 1'b0;
      flow_r      <= '0;
      flow_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      heater_r    <= heater_nxt;
      heater_ok_r <= heater_ok_nxt;
      flow_r      <= flow_nxt;
      flow_ok_r   <= flow_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_kind;
      addr_r  <= in_mac_address;
      dtype_r <= in_device_type;
    end
    if (resolving) begin
      found_r <= hit;
      index_r <= result_idx;
      added_r <= do_append;
      full_r  <= do_refuse;
    end
  end

  // --------------------------------------------------------------------------
  // Row of entry cells. Each cell passes its valid bit to its right neighbor;
  // the leftmost cell always sees an occupied neighbor.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic left_valid;
    if (g == 0) begin : g_head
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_valid = cell_valid[g-1];
    end

    pat_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_valid (left_valid),
      .valid      (cell_valid[g]),
      .match      (cell_match[g])
    );
  end

  pat_hit_or #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_hit_or (
    .match   (cell_match),
    .hit     (hit),
    .hit_idx (hit_idx)
  );

  // --------------------------------------------------------------------------
  // Outputs. Indices are reported in their low SLOT_W bits; a narrower table
  // index is zero-extended first.
  // --------------------------------------------------------------------------
  logic [IDX_W+SLOT_W-1:0] index_ext;
  logic [IDX_W+SLOT_W-1:0] heater_ext;
  logic [IDX_W+SLOT_W-1:0] flow_ext;

  assign index_ext  = {{SLOT_W{1'b0}}, index_r};
  assign heater_ext = {{SLOT_W{1'b0}}, heater_r};
  assign flow_ext   = {{SLOT_W{1'b0}}, flow_r};

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_entry_index  = index_ext[SLOT_W-1:0];
  assign out_added        = added_r;
  assign out_table_full   = full_r;
  assign out_heater_slot  = heater_ext[SLOT_W-1:0];
  assign out_heater_known = heater_ok_r;
  assign out_flow_slot    = flow_ext[SLOT_W-1:0];
  assign out_flow_known   = flow_ok_r;

endmodule : peer_address_table

`default_nettype wire
